[design/bitmap_page_allocator_assert.svh]
// assertion macros for the page allocator
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page allocator assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page allocator assertion failed");

`endif

[design/bpa_pkg.sv]
package bpa_pkg;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bpa_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_BADADDR  = 2'd2,
    ST_NOTALLOC = 2'd3
  } bpa_status_t;

  typedef struct packed {
    bpa_op_t     op;
    logic [31:0] free_address;
  } bpa_req_t;

  typedef struct packed {
    bpa_status_t status;
    logic [31:0] page_address;
  } bpa_rsp_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,
    DP_LOAD,
    DP_SCAN_RD,
    DP_SCAN_CHK,
    DP_INDEX,
    DP_ADDR,
    DP_ALLOC_WR,
    DP_RANGE,
    DP_DIV,
    DP_FREE_RD,
    DP_FREE_WR
  } bpa_dp_op_t;

  typedef struct packed {
    bpa_dp_op_t  dp_op;
    logic        respond;
    bpa_status_t status;
  } bpa_cmd_t;

  typedef struct packed {
    logic word_full;
    logic last_word;
    logic addr_ovf;
    logic range_bad;
    logic bit_clear;
  } bpa_stat_t;

endpackage

[design/bpa_ram.sv]
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/bpa_ctrl.sv]
module bpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bpa_pkg::bpa_op_t   req_op,
  input  bpa_pkg::bpa_stat_t stat,
  output bpa_pkg::bpa_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_IDX,
    S_A_ADDR,
    S_A_FIN,
    S_F_RNG,
    S_F_DIV,
    S_F_RD,
    S_F_TST
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.dp_op   = bpa_pkg::DP_NONE;
    cmd.respond = 1'b0;
    cmd.status  = bpa_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.dp_op = bpa_pkg::DP_CLEAR;
        if (stat.last_word) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.dp_op  = bpa_pkg::DP_LOAD;
          state_next = (req_op == bpa_pkg::OP_FREE) ? S_F_RNG : S_A_RD;
        end
      end
      S_A_RD: begin
        cmd.dp_op  = bpa_pkg::DP_SCAN_RD;
        state_next = S_A_CHK;
      end
      S_A_CHK: begin
        cmd.dp_op = bpa_pkg::DP_SCAN_CHK;
        if (!stat.word_full) begin
          state_next = S_A_IDX;
        end else if (stat.last_word) begin
          cmd.respond = 1'b1;
          cmd.status  = bpa_pkg::ST_NOMEM;
          state_next  = S_IDLE;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_IDX: begin
        cmd.dp_op  = bpa_pkg::DP_INDEX;
        state_next = S_A_ADDR;
      end
      S_A_ADDR: begin
        cmd.dp_op  = bpa_pkg::DP_ADDR;
        state_next = S_A_FIN;
      end
      S_A_FIN: begin
        cmd.respond = 1'b1;
        if (stat.addr_ovf) begin
          cmd.status = bpa_pkg::ST_NOMEM;
        end else begin
          cmd.dp_op  = bpa_pkg::DP_ALLOC_WR;
          cmd.status = bpa_pkg::ST_OK;
        end
        state_next = S_IDLE;
      end
      S_F_RNG: begin
        if (stat.range_bad) begin
          cmd.respond = 1'b1;
          cmd.status  = bpa_pkg::ST_BADADDR;
          state_next  = S_IDLE;
        end else begin
          cmd.dp_op  = bpa_pkg::DP_RANGE;
          state_next = S_F_DIV;
        end
      end
      S_F_DIV: begin
        cmd.dp_op  = bpa_pkg::DP_DIV;
        state_next = S_F_RD;
      end
      S_F_RD: begin
        cmd.dp_op  = bpa_pkg::DP_FREE_RD;
        state_next = S_F_TST;
      end
      S_F_TST: begin
        cmd.respond = 1'b1;
        if (stat.bit_clear) begin
          cmd.status = bpa_pkg::ST_NOTALLOC;
        end else begin
          cmd.dp_op  = bpa_pkg::DP_FREE_WR;
          cmd.status = bpa_pkg::ST_OK;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.respond;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

[design/bpa_dp.sv]
module bpa_dp #(
  parameter int NUM_WORDS       = 256,
  parameter int WORD_BITS       = 64,
  parameter int PAGE_SHIFT_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  bpa_pkg::bpa_cmd_t  cmd,
  input  bpa_pkg::bpa_req_t  req,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  output bpa_pkg::bpa_stat_t stat,
  output bpa_pkg::bpa_rsp_t  result
);

  localparam int WW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam int IDX_W = $clog2(NUM_WORDS * WORD_BITS);
  localparam int PS    = PAGE_SHIFT_BITS;
  localparam int SUM_W = ((IDX_W + PS > 32) ? (IDX_W + PS) : 32) + 1;
  localparam logic [63:0] TOTAL_BYTES =
    (64'(NUM_WORDS) * 64'(WORD_BITS)) << PAGE_SHIFT_BITS;
  // reciprocal of the word width, exact over every page index
  localparam int RW    = IDX_W + 2;
  localparam int SH    = IDX_W + BW;
  localparam int PW    = IDX_W + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  logic [31:0]          ram_base;
  logic [WW-1:0]        ptr;
  logic [WW-1:0]        low_word;
  logic [31:0]          free_addr;
  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] oh_r;
  logic [IDX_W-1:0]     idx_r;
  logic [31:0]          addr_r;
  logic                 ovf_r;
  logic [IDX_W-1:0]     dv;
  logic [BW-1:0]        rem;
  logic [WW-1:0]        qw;

  logic                 ram_wr_en;
  logic [WW-1:0]        ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [WW-1:0]        ram_rd_addr;
  logic [WORD_BITS-1:0] ram_rd_data;

  logic [WORD_BITS-1:0] word_inc;
  logic [WORD_BITS-1:0] oh_next;
  logic [BW-1:0]        bit_sel;
  logic [IDX_W-1:0]     idx_next;
  logic [SUM_W-1:0]     a_ext;
  logic                 ovf_next;
  logic [31:0]          off;
  logic [IDX_W-1:0]     free_idx;
  logic [PW-1:0]        quo_prod;
  logic [WORD_BITS-1:0] bit_mask;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // lowest clear bit of the fetched word
  assign word_inc = ram_rd_data + WORD_BITS'(1);
  assign oh_next  = ~ram_rd_data & word_inc;

  always_comb begin
    bit_sel = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh_r[i]) begin
        bit_sel = bit_sel | BW'(i);
      end
    end
  end

  assign idx_next = IDX_W'(IDX_W'(ptr) * IDX_W'(WORD_BITS)) + IDX_W'(bit_sel);

  // page must end at or below the top of the 32-bit space
  assign a_ext    = SUM_W'(ram_base) + (SUM_W'(idx_r) << PS);
  assign ovf_next = (|a_ext[SUM_W-1:32]) | ((&a_ext[31:PS]) & (|a_ext[PS-1:0]));

  assign off      = free_addr - ram_base;
  assign free_idx = IDX_W'(off >> PS);

  // word of the page index by reciprocal multiply
  assign quo_prod = PW'(dv) * PW'(RECIP);

  assign bit_mask = WORD_BITS'(1) << rem;

  assign stat.word_full = &ram_rd_data;
  assign stat.last_word = (ptr == WW'(NUM_WORDS - 1));
  assign stat.addr_ovf  = ovf_r;
  assign stat.range_bad = (free_addr < ram_base) || (64'(off) >= TOTAL_BYTES) ||
                          (|free_addr[PS-1:0]) || (|off[PS-1:0]);
  assign stat.bit_clear = !ram_rd_data[rem];

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = ptr;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = ptr;
    case (cmd.dp_op)
      bpa_pkg::DP_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      bpa_pkg::DP_SCAN_RD: begin
        ram_rd_en = 1'b1;
      end
      bpa_pkg::DP_ALLOC_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = word_r | oh_r;
      end
      bpa_pkg::DP_FREE_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = qw;
      end
      bpa_pkg::DP_FREE_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = qw;
        ram_wr_data = ram_rd_data & ~bit_mask;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_base <= '0;
      ptr      <= '0;
      low_word <= '0;
    end else begin
      if (cfg_wr_en) begin
        ram_base <= cfg_wr_data;
      end
      case (cmd.dp_op)
        bpa_pkg::DP_CLEAR: begin
          ptr <= ptr + WW'(1);
        end
        bpa_pkg::DP_LOAD: begin
          ptr <= low_word;
        end
        bpa_pkg::DP_SCAN_CHK: begin
          if (stat.word_full && !stat.last_word) begin
            ptr <= ptr + WW'(1);
          end
        end
        bpa_pkg::DP_ALLOC_WR: begin
          low_word <= ptr;
        end
        bpa_pkg::DP_FREE_WR: begin
          if (qw < low_word) begin
            low_word <= qw;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.dp_op)
      bpa_pkg::DP_LOAD: begin
        free_addr <= req.free_address;
      end
      bpa_pkg::DP_SCAN_CHK: begin
        word_r <= ram_rd_data;
        oh_r   <= oh_next;
      end
      bpa_pkg::DP_INDEX: begin
        idx_r <= idx_next;
      end
      bpa_pkg::DP_ADDR: begin
        addr_r <= a_ext[31:0];
        ovf_r  <= ovf_next;
      end
      bpa_pkg::DP_RANGE: begin
        dv <= free_idx;
      end
      bpa_pkg::DP_DIV: begin
        qw <= quo_prod[SH +: WW];
      end
      bpa_pkg::DP_FREE_RD: begin
        rem <= BW'(dv - IDX_W'(IDX_W'(qw) * IDX_W'(WORD_BITS)));
      end
      default: begin
      end
    endcase
    if (cmd.respond) begin
      result.status       <= cmd.status;
      result.page_address <= (cmd.dp_op == bpa_pkg::DP_ALLOC_WR) ? addr_r : '0;
    end
  end

endmodule

[design/bitmap_page_allocator.sv]
// alloc: scan from the lowest word that may hold a free page, skipping full words;
//   out of memory when the scan reaches a full last word
// free: word and bit split by a reciprocal multiply; a rejected address skips the split
// one transaction at a time, start taken when busy is low
// reset: bitmap cleared one word per cycle, busy high until the last word is cleared
// done pulses one cycle with result; the receiver cannot stall
module bitmap_page_allocator #(
  parameter int NUM_WORDS       = 256,
  parameter int WORD_BITS       = 64,
  parameter int PAGE_SHIFT_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bpa_pkg::bpa_req_t request,
  output logic              done,
  output bpa_pkg::bpa_rsp_t result,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);

  bpa_pkg::bpa_cmd_t  cmd;
  bpa_pkg::bpa_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req_op (request.op),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bpa_dp #(
    .NUM_WORDS       (NUM_WORDS),
    .WORD_BITS       (WORD_BITS),
    .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req         (request),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .result      (result)
  );

`include "bitmap_page_allocator_assert.svh"

  `BPA_ASSERT_IMPLY(a_done_idle, done, !busy)
  `BPA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `BPA_ASSERT_IMPLY(a_fail_zero, done && result.status != bpa_pkg::ST_OK, result.page_address == '0)
  `BPA_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int NUM_WORDS = 256;
  localparam int WORD_BITS = 64;
  localparam int PAGE_SHIFT_BITS = 12;
  localparam int TOTAL_PAGES = NUM_WORDS * WORD_BITS;
  localparam longint PAGE_BYTES = 64'd1 << PAGE_SHIFT_BITS;
  localparam logic [31:0] REGION_BYTES = 32'(TOTAL_PAGES) << PAGE_SHIFT_BITS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 75;

  typedef enum logic {
    ROW_ITEM,
    ROW_BASE
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [31:0]        base_val;
    bpa_pkg::bpa_req_t  req;
    logic               typed;
    bpa_pkg::bpa_rsp_t  rsp;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  bpa_pkg::bpa_req_t request;
  logic              done;
  bpa_pkg::bpa_rsp_t result;
  logic              cfg_wr_en;
  logic [31:0]       cfg_wr_data;

  // allocator state as predicted
  logic [WORD_BITS-1:0] used_map [NUM_WORDS];
  logic [31:0]          ram_base;
  int                   live_pages[$];

  bpa_pkg::bpa_rsp_t expected_rsp_q[$];
  int       mismatch_cnt = 0;
  int       status_hits[4] = '{0, 0, 0, 0};
  int       alloc_cnt = 0;
  int       free_cnt = 0;
  int       base_writes = 0;
  int       idle_pct = 18;
  int       quiet_cycles = 0;

  stim_row_t dir_rows [29] = '{
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_ALLOC, 32'h0000_0000}, 1'b1,
      '{bpa_pkg::ST_OK, 32'h0000_0000}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_ALLOC, 32'h0000_0000}, 1'b1,
      '{bpa_pkg::ST_OK, 32'h0000_1000}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_0000}, 1'b1, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_0000}, 1'b1,
      '{bpa_pkg::ST_NOTALLOC, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_1001}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0400_0000}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'hFFFF_FFFF}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'hFFFF_F000}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_ALLOC, 32'h0000_0000}, 1'b1,
      '{bpa_pkg::ST_OK, 32'h0000_0000}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h03FF_F000}, 1'b1,
      '{bpa_pkg::ST_NOTALLOC, 32'h0}},
    '{ROW_BASE, 32'hFFFF_F000, '{bpa_pkg::OP_ALLOC, 32'h0}, 1'b0, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_ALLOC, 32'h0000_0000}, 1'b1,
      '{bpa_pkg::ST_NOMEM, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'hFFFF_F000}, 1'b1, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_ALLOC, 32'h0000_0000}, 1'b0, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'hFFFF_E000}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_0000}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_BASE, 32'h0000_0800, '{bpa_pkg::OP_ALLOC, 32'h0}, 1'b0, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_0800}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_1000}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_ALLOC, 32'hFFFF_FFFF}, 1'b0, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_BASE, 32'hFFFF_FFFF, '{bpa_pkg::OP_ALLOC, 32'h0}, 1'b0, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_ALLOC, 32'h0000_0000}, 1'b1,
      '{bpa_pkg::ST_NOMEM, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'hFFFF_FFFF}, 1'b1,
      '{bpa_pkg::ST_BADADDR, 32'h0}},
    '{ROW_BASE, 32'h0000_0000, '{bpa_pkg::OP_ALLOC, 32'h0}, 1'b0, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_1000}, 1'b1, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_2000}, 1'b1, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_0000}, 1'b1, '{bpa_pkg::ST_OK, 32'h0}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_ALLOC, 32'h0000_0000}, 1'b1,
      '{bpa_pkg::ST_OK, 32'h0000_0000}},
    '{ROW_ITEM, 32'h0, '{bpa_pkg::OP_FREE, 32'h0000_0000}, 1'b1, '{bpa_pkg::ST_OK, 32'h0}}
  };

  bitmap_page_allocator #(
    .NUM_WORDS      (NUM_WORDS),
    .WORD_BITS      (WORD_BITS),
    .PAGE_SHIFT_BITS(PAGE_SHIFT_BITS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first fit over the used map; pg is the page whose bit changed, or -1
  function automatic bpa_pkg::bpa_rsp_t predict_page_op(input bpa_pkg::bpa_req_t req,
                                                        output int pg);
    bpa_pkg::bpa_rsp_t r;
    logic [63:0] a64;
    logic [63:0] base64;
    logic [63:0] end_addr;
    logic [63:0] off;
    int          idx;
    bit          found;
    r.status = bpa_pkg::ST_OK;
    r.page_address = '0;
    pg = -1;
    found = 1'b0;
    base64 = {32'd0, ram_base};
    if (req.op == bpa_pkg::OP_ALLOC) begin
      r.status = bpa_pkg::ST_NOMEM;
      for (int w = 0; w < NUM_WORDS && !found; w++) begin
        if (&used_map[w]) continue;
        for (int b = 0; b < WORD_BITS && !found; b++) begin
          if (!used_map[w][b]) begin
            found = 1'b1;
            idx = w * WORD_BITS + b;
            a64 = base64 + (64'(idx) << PAGE_SHIFT_BITS);
            // a page reaching past the 32-bit space is never handed out
            if (a64 + PAGE_BYTES - 1 <= 64'hFFFF_FFFF) begin
              used_map[w][b] = 1'b1;
              r.status = bpa_pkg::ST_OK;
              r.page_address = a64[31:0];
              pg = idx;
            end
          end
        end
      end
    end else begin
      a64 = {32'd0, req.free_address};
      end_addr = base64 + (64'(TOTAL_PAGES) << PAGE_SHIFT_BITS);
      off = a64 - base64;
      if (a64 < base64 || a64 >= end_addr || a64[PAGE_SHIFT_BITS-1:0] != '0 ||
          off[PAGE_SHIFT_BITS-1:0] != '0) begin
        r.status = bpa_pkg::ST_BADADDR;
      end else begin
        idx = int'(off >> PAGE_SHIFT_BITS);
        if (!used_map[idx / WORD_BITS][idx % WORD_BITS]) begin
          r.status = bpa_pkg::ST_NOTALLOC;
        end else begin
          used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
          pg = idx;
        end
      end
    end
    return r;
  endfunction

  function automatic bpa_pkg::bpa_req_t random_item(input int alloc_pct);
    bpa_pkg::bpa_req_t req;
    int       roll;
    int       k;
    req.free_address = $urandom;
    roll = $urandom_range(99);
    if (roll < alloc_pct) begin
      req.op = bpa_pkg::OP_ALLOC;
    end else begin
      req.op = bpa_pkg::OP_FREE;
      // mostly frees of pages in use, the rest stray addresses
      if (roll < alloc_pct + (100 - alloc_pct) * 3 / 4 && live_pages.size() != 0) begin
        k = $urandom_range(live_pages.size() - 1);
        req.free_address = ram_base + (32'(live_pages[k]) << PAGE_SHIFT_BITS);
      end else begin
        case ($urandom_range(3))
          0: ;
          1: req.free_address = ram_base +
                                (32'($urandom_range(TOTAL_PAGES - 1)) << PAGE_SHIFT_BITS);
          2: req.free_address = $urandom_range(1) ? ram_base + REGION_BYTES
                                                  : ram_base - 32'(PAGE_BYTES);
          default: req.free_address = ram_base +
                                      (32'($urandom_range(TOTAL_PAGES - 1)) << PAGE_SHIFT_BITS) +
                                      32'($urandom_range(1, PAGE_BYTES - 1));
        endcase
      end
    end
    return req;
  endfunction

  // returns at the falling edge after the transaction is taken, start still high
  task automatic issue_item(input bpa_pkg::bpa_req_t req, input bit typed,
                            input bpa_pkg::bpa_rsp_t typed_rsp);
    bpa_pkg::bpa_rsp_t r;
    int       pg;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_page_op(req, pg);
    expected_rsp_q.push_back(typed ? typed_rsp : r);
    if (req.op == bpa_pkg::OP_ALLOC) begin
      alloc_cnt++;
      if (pg >= 0) live_pages.push_back(pg);
    end else begin
      free_cnt++;
      if (pg >= 0) begin
        foreach (live_pages[i]) begin
          if (live_pages[i] == pg) begin
            live_pages.delete(i);
            break;
          end
        end
      end
    end
    @(negedge clk);
  endtask

  task automatic set_ram_base(input logic [31:0] value);
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ram_base = value;
    base_writes++;
  endtask

  task automatic note_mismatch(input string what, input bpa_pkg::bpa_rsp_t want,
                               input bpa_pkg::bpa_rsp_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch at %0t (%s): expected status %0d addr %h, got status %0d addr %h",
               $realtime, what, want.status, want.page_address, got.status,
               got.page_address);
  endtask

  // response checker
  always @(posedge clk) begin
    bpa_pkg::bpa_rsp_t want;
    if (!rst && done) begin
      if (expected_rsp_q.size() == 0) begin
        note_mismatch("no transaction pending", '0, result);
      end else begin
        want = expected_rsp_q.pop_front();
        status_hits[want.status]++;
        if (result.status !== want.status || result.page_address !== want.page_address)
          note_mismatch("wrong result", want, result);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] b;
    int          alloc_pct;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    ram_base = '0;
    foreach (used_map[w]) used_map[w] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // bitmap clear pass
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_BASE) set_ram_base(dir_rows[i].base_val);
      else issue_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    end

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = 18;
      case (ph)
        0: begin
          b = 32'h0000_0000;
          alloc_pct = 60;
        end
        1: begin
          b = 32'h8000_0000;
          alloc_pct = 85;
          idle_pct = 0;
        end
        2: begin
          b = 32'hFFFF_0000;
          alloc_pct = 55;
        end
        3: begin
          b = $urandom & 32'hFFFF_F000;
          alloc_pct = 50;
        end
        4: begin
          b = $urandom;
          if (b[PAGE_SHIFT_BITS-1:0] == '0) b[0] = 1'b1;
          alloc_pct = 50;
        end
        default: begin
          b = 32'hFBFF_F000;
          alloc_pct = 40;
        end
      endcase
      set_ram_base(b);
      repeat (PHASE_ITEMS) issue_item(random_item(alloc_pct), 1'b0, '0);
    end

    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("%0d allocations and %0d frees over %0d base settings, %0d pages left in use",
             alloc_cnt, free_cnt, base_writes, live_pages.size());
    $display("results: %0d ok, %0d out of memory, %0d bad address, %0d not allocated",
             status_hits[bpa_pkg::ST_OK], status_hits[bpa_pkg::ST_NOMEM],
             status_hits[bpa_pkg::ST_BADADDR], status_hits[bpa_pkg::ST_NOTALLOC]);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
